FILE: rtl/c3f_pkg.sv
// ---------------------------------------------------------------------------
// c3f_pkg
// Shared constants and types of the 3x3 convolution image filter: register
// indexes, filter codes, stream codes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package c3f_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int CHANNELS_DEF   = 3;

  localparam int PIX_W  = 24;
  localparam int LINE_W = 2 * PIX_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_COLOR_MODE   = 2'd3
  } cfg_reg_t;

  // filter codes
  localparam logic [2:0] MODE_SMOOTH  = 3'd0;
  localparam logic [2:0] MODE_BLUR    = 3'd1;
  localparam logic [2:0] MODE_SHARPEN = 3'd2;
  localparam logic [2:0] MODE_MEAN    = 3'd3;
  localparam logic [2:0] MODE_EMBOSS  = 3'd4;

  // input kinds carried in tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // reset values of the registers
  localparam logic [2:0]  FILTER_MODE_RST  = MODE_SMOOTH;
  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic        COLOR_MODE_RST   = 1'b0;

  // reciprocals for the exact divisions by 9 and by 3 over the sum ranges
  localparam int          RECIP_SHIFT = 16;
  localparam logic [15:0] RECIP9      = 16'd7282;
  localparam logic [15:0] RECIP3      = 16'd21846;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // what one item makes once it leaves the line buffer stage
  typedef struct packed {
    logic drain;   // drain tick, emits the previous row half of the line buffer word
    logic last;    // drain tick that closes the frame
    logic pre;     // border pixel of two rows up at the start of a row
    logic mid;     // the window centre result
    logic border;  // window centre sits on the border
    logic fin;     // last pixel also emits the next to last row's end
  } emit_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] px;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/c3f_ram.sv
// ---------------------------------------------------------------------------
// c3f_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module c3f_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/conv3x3_image_filter_unit.sv
// ---------------------------------------------------------------------------
// conv3x3_image_filter_unit
// 3x3 convolution filter over a raster-order pixel stream, grey or color.
// ---------------------------------------------------------------------------
// Takes one pixel or drain tick per clock while the output queue has room and
// gives one result per clock while m_axis_tready is high. Each pixel reads its
// column from a single line buffer RAM (previous and second previous row side
// by side) through a registered read issued on acceptance; when the line buffer
// stage fires, the 3x3 window shifts and the result stage takes the item, whose
// result is computed from the window registers and written into the output
// queue. Output lags the input by one row and one pixel; after the frame's last
// pixel, as many drain ticks as the clamped frame width flush the last row, the
// final one carrying tlast. An item makes at most two results; the input is held
// off only while the eight-entry output queue has fewer than four free places.
// Border pixels pass unchanged. Configuration is written through the cfg channel
// by the user only while the block is idle; the block does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module conv3x3_image_filter_unit
  import c3f_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int CHANNELS   = CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,  // sample_0, sample_1, sample_2
  input  wire logic                  s_axis_tuser,  // op
  // filtered output
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // out_0, out_1, out_2
  output logic                       m_axis_tlast   // frame_last
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // ------------------------------------------------------------------------
  // per channel kernel, exact sums, truncation toward zero, saturation
  // ------------------------------------------------------------------------
  function automatic logic [7:0] sat8(input logic signed [13:0] v);
    logic [7:0] r;
    if (v < 14'sd0) begin
      r = 8'd0;
    end else if (v > 14'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] filter_chan(input logic [2:0] mode,
                                             input logic [8:0][7:0] p);
    logic [11:0]        sum9;
    logic [9:0]         cross_sum;
    logic [9:0]         corner;
    logic [11:0]        blur;
    logic signed [13:0] s;
    logic [27:0]        prod;
    logic [7:0]         r;
    sum9      = 12'(p[0]) + 12'(p[1]) + 12'(p[2]) + 12'(p[3]) + 12'(p[4])
              + 12'(p[5]) + 12'(p[6]) + 12'(p[7]) + 12'(p[8]);
    cross_sum = 10'(p[1]) + 10'(p[3]) + 10'(p[5]) + 10'(p[7]);
    corner    = 10'(p[0]) + 10'(p[2]) + 10'(p[6]) + 10'(p[8]);
    blur      = 12'(corner) + {1'b0, cross_sum, 1'b0} + {2'b0, p[4], 2'b0};
    s         = '0;
    prod      = '0;
    unique case (mode)
      MODE_SMOOTH: begin
        prod = 28'(sum9) * 28'(RECIP9);
        r    = 8'(prod >> RECIP_SHIFT);
      end
      MODE_BLUR: begin
        r = blur[11:4];
      end
      MODE_SHARPEN: begin
        s = $signed(14'(p[4]) * 14'd11) - $signed({3'b0, cross_sum, 1'b0});
        if (s <= 14'sd0) begin
          r = 8'd0;
        end else begin
          // positive part only, so truncation is a plain floor
          prod = 28'(s[12:0]) * 28'(RECIP3);
          r    = sat8($signed(14'(prod >> RECIP_SHIFT)));
        end
      end
      MODE_MEAN: begin
        s = $signed(14'(p[4]) * 14'd10) - $signed(14'(sum9));
        r = sat8(s);
      end
      MODE_EMBOSS: begin
        s = $signed(14'(p[1])) - $signed(14'(p[7]));
        r = sat8(s);
      end
      default: begin
        r = p[4];
      end
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------------
  logic [2:0]  filter_mode;
  logic [11:0] frame_width;
  logic [12:0] frame_height;
  logic        color_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= FILTER_MODE_RST;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      color_mode   <= COLOR_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILTER_MODE:  filter_mode  <= cfg_data[2:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[11:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
      endcase
    end
  end

  // last column and last row after clamping the frame size
  logic [COL_W-1:0] width_m1;
  logic [ROW_W-1:0] height_m1;

  always_comb begin
    if (frame_width < 12'd3) begin
      width_m1 = COL_W'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_m1 = COL_W'(frame_width - 12'd1);
    end
    if (frame_height < 13'd3) begin
      height_m1 = ROW_W'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_m1 = ROW_W'(frame_height - 13'd1);
    end
  end

  // ------------------------------------------------------------------------
  // raster counters, advanced when an item is accepted
  // ------------------------------------------------------------------------
  logic [COL_W-1:0] col_index;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] drain_index;

  logic             accept;
  logic             in_drain;
  logic             col_end;
  logic             frm_end;
  logic             drain_last;
  logic [COL_W-1:0] rd_addr;
  emit_t            in_emit;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign in_drain   = (s_axis_tuser == OP_DRAIN);
  assign col_end    = (col_index >= width_m1);
  assign frm_end    = col_end && (row_index >= height_m1);
  assign drain_last = (drain_index >= width_m1);
  assign rd_addr    = in_drain ? drain_index : col_index;

  always_comb begin
    in_emit = '0;
    if (in_drain) begin
      in_emit.drain = 1'b1;
      in_emit.last  = drain_last;
    end else begin
      in_emit.pre    = (col_index == '0) && (row_index >= ROW_W'(2));
      in_emit.mid    = (col_index != '0) && (row_index != '0);
      in_emit.border = (row_index == ROW_W'(1)) || (col_index == COL_W'(1));
      in_emit.fin    = frm_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_index   <= '0;
      row_index   <= '0;
      drain_index <= '0;
    end else if (accept) begin
      if (in_drain) begin
        drain_index <= drain_last ? '0 : drain_index + COL_W'(1);
      end else if (frm_end) begin
        col_index   <= '0;
        row_index   <= '0;
        drain_index <= '0;
      end else if (col_end) begin
        col_index <= '0;
        row_index <= row_index + ROW_W'(1);
      end else begin
        col_index <= col_index + COL_W'(1);
      end
    end
  end

  // ------------------------------------------------------------------------
  // line buffer stage: item waits here for its RAM word
  // ------------------------------------------------------------------------
  logic              a_valid;
  emit_t             a_emit;
  logic [COL_W-1:0]  a_addr;
  logic [PIX_W-1:0]  a_px;
  logic              a_fwd_hit;
  logic [LINE_W-1:0] a_fwd_data;
  logic              a_fire;
  logic              fifo_room;

  logic [LINE_W-1:0] ram_rd_data;
  logic [LINE_W-1:0] line_word;
  logic [PIX_W-1:0]  line_above;
  logic [PIX_W-1:0]  line_two_above;
  logic              wr_en;
  logic [LINE_W-1:0] wr_data;

  assign a_fire        = a_valid && fifo_room;
  assign s_axis_tready = !a_valid || a_fire;

  // a write in the read cycle to the same column is taken from the bypass
  assign line_word      = a_fwd_hit ? a_fwd_data : ram_rd_data;
  assign line_above     = line_word[PIX_W-1:0];
  assign line_two_above = line_word[LINE_W-1:PIX_W];
  assign wr_en          = a_fire && !a_emit.drain;
  assign wr_data        = {line_above, a_px};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_emit     <= in_emit;
      a_addr     <= rd_addr;
      a_px       <= s_axis_tdata;
      a_fwd_hit  <= wr_en && (a_addr == rd_addr);
      a_fwd_data <= wr_data;
    end
  end

  c3f_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (a_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // ------------------------------------------------------------------------
  // 3x3 window, row 0 oldest; column 2 is the newest
  // ------------------------------------------------------------------------
  logic [PIX_W-1:0] win [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (a_fire && !a_emit.drain) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= line_two_above;
      win[5] <= line_above;
      win[8] <= a_px;
    end
  end

  // ------------------------------------------------------------------------
  // result stage: filter from the window registers, push into the queue
  // ------------------------------------------------------------------------
  logic             c_valid;
  emit_t            c_emit;
  logic [PIX_W-1:0] c_val0;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= a_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      c_emit <= a_emit;
      c_val0 <= a_emit.drain ? line_above : win[5];
    end
  end

  logic [PIX_W-1:0] filt_px;
  logic [8:0][7:0]  chan_win;

  always_comb begin
    chan_win = '0;
    filt_px  = '0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 9; i++) begin
        chan_win[i] = win[i][8*k +: 8];
      end
      filt_px[8*k +: 8] = filter_chan(filter_mode, chan_win);
    end
  end

  logic             slot0;
  logic             slot1;
  logic             slot2;
  logic [PIX_W-1:0] val1;
  res_t             e0_raw;
  res_t             e0;
  res_t             e1;
  logic             push0;
  logic             push1;

  assign slot0 = c_valid && (c_emit.drain || c_emit.pre);
  assign slot1 = c_valid && c_emit.mid;
  assign slot2 = c_valid && c_emit.fin;
  assign val1  = c_emit.border ? win[4] : filt_px;

  // start of a row and the window centre never come from the same pixel
  always_comb begin
    priority if (slot0) begin
      e0_raw = '{last: c_emit.drain && c_emit.last, px: c_val0};
    end else if (slot1) begin
      e0_raw = '{last: 1'b0, px: val1};
    end else begin
      e0_raw = '{last: 1'b0, px: win[5]};
    end
  end

  // channels beyond the configured set read as zero
  always_comb begin
    e0 = e0_raw;
    e1 = '{last: 1'b0, px: win[5]};
    for (int k = 0; k < 3; k++) begin
      if (k >= CHANNELS || (k > 0 && !color_mode)) begin
        e0.px[8*k +: 8] = 8'd0;
        e1.px[8*k +: 8] = 8'd0;
      end
    end
  end

  assign push0 = slot0 || slot1 || slot2;
  assign push1 = slot1 && slot2;

  // ------------------------------------------------------------------------
  // output queue
  // ------------------------------------------------------------------------
  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               pop;
  logic [1:0]         push_n;

  assign push_n    = {1'b0, push0} + {1'b0, push1};
  assign pop       = m_axis_tvalid && m_axis_tready;
  // room for the result stage's pushes now and next cycle
  assign fifo_room = (count <= FIFO_CW'(FIFO_DEPTH - 4));

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_mem[wr_ptr] <= e0;
    end
    if (push1) begin
      fifo_mem[wr_ptr + FIFO_AW'(1)] <= e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = fifo_mem[rd_ptr].px;
  assign m_axis_tlast  = fifo_mem[rd_ptr].last;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the 3x3 convolution image filter against its own pixel-level
// predictor. Frames of random pixels run through all kernels, grey and
// color, with border pass-through, drain flushing, partial and extra drains,
// out-of-range sizes and size changes in mid-frame. Both stream sides idle
// at random; the output side also holds off for long stretches.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import c3f_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX   = MAX_WIDTH_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 10;

  typedef struct packed {
    logic       op;
    logic [7:0] s2;
    logic [7:0] s1;
    logic [7:0] s0;
  } pix_item_t;

  typedef struct packed {
    logic       last;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } pix_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = REG_FILTER_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;  // sample_0, sample_1, sample_2
  logic                  s_axis_tuser = 1'b0;  // op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;  // out_0, out_1, out_2
  logic                  m_axis_tlast;  // frame_last

  conv3x3_image_filter_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // filter state as the predictor sees it
  logic [23:0]  row_prev  [LINE_MAX];
  logic [23:0]  row_prev2 [LINE_MAX];
  logic [23:0]  win [9];
  int unsigned  at_row, at_col, flush_col;
  logic [2:0]   k_mode;
  logic [11:0]  f_width;
  logic [12:0]  f_height;
  logic         rgb_on;

  pix_out_t     out_pixels_q [$];
  pix_item_t    pixel_in_q [$];

  int           n_err, n_queued, n_accepted;
  int           gen_row, gen_col;
  int           tx_gap, rx_gap, idle_cycles;
  bit           tx_slow = 1'b1, rx_slow = 1'b1;
  logic         hold_off = 1'b0;
  pix_item_t    tx_item;

  function automatic int unsigned eff_width();
    if (f_width < 3) return 3;
    if (f_width > LINE_MAX) return LINE_MAX;
    return f_width;
  endfunction

  function automatic int unsigned eff_height();
    if (f_height < 3) return 3;
    if (f_height > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
    return f_height;
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FILTER_MODE:  k_mode = data[2:0];
      REG_FRAME_WIDTH:  f_width = data[11:0];
      REG_FRAME_HEIGHT: f_height = data;
      REG_COLOR_MODE:   rgb_on = data[0];
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] kernel_channel(int k);
    int p [9];
    int s, i;
    for (i = 0; i < 9; i++) p[i] = int'(win[i][8*k +: 8]);
    case (k_mode)
      MODE_SMOOTH: begin
        s = 0;
        for (i = 0; i < 9; i++) s += p[i];
        s = s / 9;
      end
      MODE_BLUR:
        s = (p[0] + p[2] + p[6] + p[8] + 2 * (p[1] + p[3] + p[5] + p[7]) + 4 * p[4]) / 16;
      MODE_SHARPEN:
        s = (11 * p[4] - 2 * (p[1] + p[3] + p[5] + p[7])) / 3;
      MODE_MEAN: begin
        s = 10 * p[4];
        for (i = 0; i < 9; i++) s -= p[i];
      end
      MODE_EMBOSS:
        s = p[1] - p[7];
      default:
        s = p[4];
    endcase
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return s[7:0];
  endfunction

  function automatic void push_pixel(logic [23:0] px, logic last);
    pix_out_t o;
    o.c0   = px[7:0];
    o.c1   = rgb_on ? px[15:8] : 8'd0;
    o.c2   = rgb_on ? px[23:16] : 8'd0;
    o.last = last;
    out_pixels_q.push_back(o);
  endfunction

  // one accepted item through the line buffers and the window
  function automatic void filter_step(pix_item_t it);
    int unsigned w, h, r, c, d, k;
    logic        last;
    logic [23:0] px;
    w = eff_width();
    h = eff_height();
    if (it.op == OP_DRAIN) begin
      d = flush_col;
      last = (d >= w - 1);
      if (d >= LINE_MAX) d = 0;
      push_pixel(row_prev[d], last);
      flush_col = last ? 0 : d + 1;
    end else begin
      r = at_row;
      c = at_col;
      px = {it.s2, it.s1, it.s0};
      if (c >= LINE_MAX) c = LINE_MAX - 1;
      // right border pixel of two rows up
      if (c == 0 && r >= 2) push_pixel(win[5], 1'b0);
      for (k = 0; k < 3; k++) begin
        win[3*k]   = win[3*k+1];
        win[3*k+1] = win[3*k+2];
      end
      win[2] = row_prev2[c];
      win[5] = row_prev[c];
      win[8] = px;
      row_prev2[c] = row_prev[c];
      row_prev[c]  = px;
      if (c >= 1 && r >= 1) begin
        if (r == 1 || c == 1) push_pixel(win[4], 1'b0);
        else push_pixel({kernel_channel(2), kernel_channel(1), kernel_channel(0)}, 1'b0);
      end
      if (r >= h - 1 && c >= w - 1) begin
        push_pixel(win[5], 1'b0);
        at_row = 0;
        at_col = 0;
        flush_col = 0;
      end else if (c >= w - 1) begin
        at_col = 0;
        at_row = r + 1;
      end else begin
        at_col = c + 1;
      end
    end
  endfunction

  task automatic report_mismatch(string what);
    n_err++;
    if (n_err <= 40) $display("%0t ns: %s", $time, what);
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        filter_step(tx_item);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_in_q.size() != 0) begin
          tx_item = pixel_in_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {tx_item.s2, tx_item.s1, tx_item.s0};
          s_axis_tuser  <= tx_item.op;
          tx_gap = tx_slow ? $urandom_range(0, 5) : 0;
          if ($urandom_range(0, 63) == 0) tx_slow = !tx_slow;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    pix_out_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (out_pixels_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction data %h last %b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          want = out_pixels_q.pop_front();
          if (m_axis_tdata[7:0] !== want.c0)
            report_mismatch($sformatf("out_0 got %h want %h", m_axis_tdata[7:0], want.c0));
          if (m_axis_tdata[15:8] !== want.c1)
            report_mismatch($sformatf("out_1 got %h want %h", m_axis_tdata[15:8], want.c1));
          if (m_axis_tdata[23:16] !== want.c2)
            report_mismatch($sformatf("out_2 got %h want %h", m_axis_tdata[23:16], want.c2));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("frame_last got %b want %b", m_axis_tlast, want.last));
        end
        rx_gap = rx_slow ? $urandom_range(0, 5) : 0;
        if ($urandom_range(0, 63) == 0) rx_slow = !rx_slow;
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-offs while the input keeps offering
  initial begin
    int i;
    for (i = 1; i <= 2; i++) begin
      do @(posedge clk); while (!(pixel_in_q.size() > 30 && n_accepted > 100 * i));
      hold_off <= 1'b1;
      repeat (120) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_in_q.size() != 0 || s_axis_tvalid || out_pixels_q.size() != 0);
    // items that make no result may still be in the pipeline
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // raster position of the next queued pixel, used to shape frames
  function automatic void queue_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int unsigned w, h;
    w = eff_width();
    h = eff_height();
    pixel_in_q.push_back('{op: OP_PIXEL, s2: c, s1: b, s0: a});
    n_queued++;
    if (gen_row >= h - 1 && gen_col >= w - 1) begin
      gen_row = 0;
      gen_col = 0;
    end else if (gen_col >= w - 1) begin
      gen_col = 0;
      gen_row++;
    end else begin
      gen_col++;
    end
  endfunction

  function automatic void queue_drain();
    pixel_in_q.push_back('{op: OP_DRAIN, s2: 8'($urandom), s1: 8'($urandom),
                           s0: 8'($urandom)});
    n_queued++;
  endfunction

  function automatic void queue_rand_pixel();
    queue_pixel(rand_level(), rand_level(), rand_level());
  endfunction

  // pixels up to the end of the current frame, a stray drain now and then
  function automatic void finish_frame();
    do begin
      queue_rand_pixel();
      if (gen_row >= 1 && $urandom_range(0, 39) == 0) queue_drain();
    end while (gen_row != 0 || gen_col != 0);
  endfunction

  function automatic void queue_drains();
    int unsigned w;
    w = eff_width();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: repeat (w) queue_drain();
      6, 7: repeat (w + $urandom_range(1, w)) queue_drain();
      8: repeat ($urandom_range(1, w - 1)) queue_drain();
      default: ;
    endcase
  endfunction

  task automatic random_config();
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_FILTER_MODE, {10'($urandom), 3'($urandom_range(0, 7))});
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0: write_reg(REG_FRAME_WIDTH, 13'($urandom_range(0, 2)));
        1: write_reg(REG_FRAME_WIDTH, {1'($urandom), 12'($urandom_range(13, 40))});
        default: write_reg(REG_FRAME_WIDTH, {1'($urandom), 12'($urandom_range(3, 12))});
      endcase
    end
    if ($urandom_range(0, 1)) begin
      if ($urandom_range(0, 7) == 0) write_reg(REG_FRAME_HEIGHT, 13'($urandom_range(0, 2)));
      else write_reg(REG_FRAME_HEIGHT, 13'($urandom_range(3, 7)));
    end
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_COLOR_MODE, {12'($urandom), 1'($urandom)});
  endtask

  initial begin
    int i, w, phase;
    k_mode    = FILTER_MODE_RST;
    f_width   = FRAME_WIDTH_RST;
    f_height  = FRAME_HEIGHT_RST;
    rgb_on    = COLOR_MODE_RST;
    foreach (row_prev[j]) begin
      row_prev[j]  = '0;
      row_prev2[j] = '0;
    end
    foreach (win[j]) win[j] = '0;
    at_row = 0;
    at_col = 0;
    flush_col = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // mean kernel saturating both ways, color
    write_reg(REG_FILTER_MODE, {10'd0, MODE_MEAN});
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_COLOR_MODE, 13'd1);
    for (i = 0; i < 9; i++) begin
      if (i == 4) queue_pixel(8'd255, 8'd0, 8'd128);
      else queue_pixel(8'd0, 8'd255, 8'd255);
    end
    // full flush and one drain beyond it
    repeat (4) queue_drain();
    wait_idle();

    // emboss in grey with sizes below the minimum; next frame starts mid-drain
    write_reg(REG_FILTER_MODE, {10'h3FF, MODE_EMBOSS});
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_COLOR_MODE, 13'h1FFE);
    for (i = 0; i < 9; i++) begin
      if (i < 3) queue_pixel(8'd255, 8'd255, 8'd255);
      else if (i < 6) queue_rand_pixel();
      else queue_pixel(8'd0, 8'd0, 8'd0);
    end
    queue_drain();

    phase = 0;
    while (n_queued < 520) begin
      wait_idle();
      if (phase == 0 || $urandom_range(0, 1)) random_config();
      if (phase == 1 || $urandom_range(0, 5) == 0) begin
        // size and kernel change in the middle of a frame
        if (gen_row != 0 || gen_col != 0) finish_frame();
        w = eff_width();
        repeat (2 * w + $urandom_range(0, w - 1)) queue_rand_pixel();
        wait_idle();
        write_reg(REG_FILTER_MODE, 13'($urandom_range(0, 7)));
        write_reg(REG_FRAME_WIDTH, 13'($urandom_range(3, w)));
        if ($urandom_range(0, 1)) write_reg(REG_FRAME_HEIGHT, 13'($urandom_range(3, 9)));
      end
      finish_frame();
      queue_drains();
      phase++;
    end

    // a larger frame queued at once keeps the input busy during a hold-off
    wait_idle();
    write_reg(REG_FILTER_MODE, 13'($urandom_range(0, 4)));
    write_reg(REG_FRAME_WIDTH, 13'd30);
    write_reg(REG_FRAME_HEIGHT, 13'd5);
    write_reg(REG_COLOR_MODE, 13'd1);
    finish_frame();
    repeat (eff_width()) queue_drain();

    wait_idle();
    if (n_err == 0 && out_pixels_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/c3f_pkg.sv
rtl/c3f_ram.sv
rtl/conv3x3_image_filter_unit.sv
tb/testbench.sv
